[rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache with LRU tie-break.
// Used by lfu_cell and lfu_cache_lru_tiebreak; depends on nothing.
package lfu_pkg;

  localparam int unsigned IDX_W  = 8;   // holds any entry index up to 255
  localparam int unsigned USED_W = 9;   // holds an occupancy up to 256
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned REC_W  = 64;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CMD_BUMP,
    CMD_WRITE,
    CMD_INSERT
  } cmd_e;

  // Summary that travels down the chain of cells during a lookup.
  typedef struct packed {
    logic [USED_W-1:0] used;
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic [VAL_W-1:0]  found_val;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              best_v;
    logic [IDX_W-1:0]  best_idx;
    logic [KEY_W-1:0]  best_key;
    logic [CNT_W-1:0]  best_cnt;
    logic [REC_W-1:0]  best_rec;
  } carry_t;

  // Update broadcast to all cells; only the addressed cell acts.
  typedef struct packed {
    logic             valid;
    cmd_e             kind;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [REC_W-1:0] stamp;
  } cmd_t;

endpackage

[rtl/lfu_cell.sv]
// One cache entry of the LFU cache and its stage of the lookup chain.
// Depends on lfu_pkg.
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KEY_W-1:0] key_i,
  input  carry_t           carry_i,
  output carry_t           carry_o,
  input  cmd_t             cmd_i
);

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REC_W-1:0] rec_q;
  carry_t           carry_d, carry_q;
  logic             sel;
  logic [CNT_W-1:0] cnt_inc;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  always_comb begin
    carry_d = carry_i;
    if (valid_q) begin
      carry_d.used = carry_i.used + USED_W'(1);
      if (!carry_i.found && key_q == key_i) begin
        carry_d.found     = 1'b1;
        carry_d.found_idx = MyIdx;
        carry_d.found_val = val_q;
      end
      if (!carry_i.best_v || cnt_q < carry_i.best_cnt ||
          (cnt_q == carry_i.best_cnt && rec_q < carry_i.best_rec)) begin
        carry_d.best_v   = 1'b1;
        carry_d.best_idx = MyIdx;
        carry_d.best_key = key_q;
        carry_d.best_cnt = cnt_q;
        carry_d.best_rec = rec_q;
      end
    end else if (!carry_i.free) begin
      carry_d.free     = 1'b1;
      carry_d.free_idx = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign carry_o = carry_q;
  assign sel     = cmd_i.valid && (cmd_i.idx == MyIdx);
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel && cmd_i.kind == CMD_INSERT) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      unique case (cmd_i.kind)
        CMD_BUMP: begin
          cnt_q <= cnt_inc;
          rec_q <= cmd_i.stamp;
        end
        CMD_WRITE: begin
          val_q <= cmd_i.value;
          cnt_q <= cnt_inc;
          rec_q <= cmd_i.stamp;
        end
        CMD_INSERT: begin
          key_q <= cmd_i.key;
          val_q <= cmd_i.value;
          cnt_q <= CNT_W'(1);
          rec_q <= cmd_i.stamp;
        end
        default: begin
          rec_q <= rec_q;
        end
      endcase
    end
  end

endmodule

[rtl/lfu_cache_lru_tiebreak.sv]
// LFU key/value cache with LRU tie-break. An accepted input beat is answered
// once the lookup summary has walked the chain of CAPACITY cells, one
// registered cell at a time, and at most one entry has been updated. A new
// beat is taken only after the previous result has entered the output register.
// Reset (rst_ni low, asynchronous) empties every entry, clears the recency
// counter and sets capacity_in_use to 16; no clearing pass is needed.
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,     // capacity_in_use
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,    // [31:0] lookup_key, [63:32] store_value
  input  logic             s_axis_tuser,    // [0] opcode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [63:0]      m_axis_tdata,    // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]       m_axis_tuser     // [0] hit, [1] evicted
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [USED_W-1:0] CapMax = USED_W'(CAPACITY);

  // Control state.
  state_e           state_q, state_d;
  logic [CW-1:0]    scan_q, scan_d;
  logic [CAP_W-1:0] cap_q;
  logic [REC_W-1:0] rec_q;
  logic             out_valid_q;

  // Captured request.
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Output payload.
  logic [1:0]       out_user_q, out_user_d;
  logic [63:0]      out_data_q, out_data_d;

  carry_t           carry [CAPACITY];
  carry_t           res;
  cmd_t             cmd;
  logic             out_free;
  logic             finish;
  logic [USED_W-1:0] cap_eff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The output slot can take a new result when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready;
  assign finish   = (state_q == ST_DONE) && out_free;

  // The chain of cells. Cell 0 starts from an empty summary; each later cell
  // merges its entry into the summary registered by its left neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    carry_t cin;
    if (g == 0) begin : g_first
      assign cin = '0;
    end else begin : g_rest
      assign cin = carry[g-1];
    end
    lfu_cell #(.INDEX(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .carry_i (cin),
      .carry_o (carry[g]),
      .cmd_i   (cmd)
    );
  end

  assign res     = carry[CAPACITY-1];
  assign cap_eff = (USED_W'(cap_q) > CapMax) ? CapMax : USED_W'(cap_q);

  // Decide the result and the entry update from the finished summary.
  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_BUMP;
    cmd.key    = key_q;
    cmd.value  = val_q;
    cmd.stamp  = rec_q + REC_W'(1);
    out_user_d = {1'b0, res.found};
    out_data_d = '0;
    if (op_q == OP_GET) begin
      if (res.found) begin
        out_data_d[31:0] = res.found_val;
        cmd.valid        = 1'b1;
        cmd.idx          = res.found_idx;
      end else begin
        out_data_d[31:0] = '1;
      end
    end else if (res.found) begin
      cmd.valid = 1'b1;
      cmd.kind  = CMD_WRITE;
      cmd.idx   = res.found_idx;
    end else if (cap_eff != '0) begin
      cmd.kind = CMD_INSERT;
      if (res.used >= cap_eff) begin
        // Full: the least used, then least recently touched, entry goes.
        if (res.best_v) begin
          cmd.valid         = 1'b1;
          cmd.idx           = res.best_idx;
          out_user_d[1]     = 1'b1;
          out_data_d[63:32] = res.best_key;
        end
      end else if (res.free) begin
        cmd.valid = 1'b1;
        cmd.idx   = res.free_idx;
      end
    end
    if (!finish) begin
      cmd.valid = 1'b0;
    end
  end

  // Sequencer: wait for the summary to reach the end of the chain, then
  // update at most one entry and hand the result to the output register.
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (s_axis_tvalid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + CW'(1);
        if (scan_q == CW'(CAPACITY - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      cap_q       <= CAP_RESET;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd.valid) begin
        rec_q <= cmd.stamp;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata[31:0];
      val_q <= s_axis_tdata[63:32];
    end
    if (finish) begin
      out_user_q <= out_user_d;
      out_data_q <= out_data_d;
    end
  end

endmodule

[rtl/lfu_checker.sv]
// Port-level checks for lfu_cache_lru_tiebreak, attached by bind.
// Depends only on the clock, reset and stream ports of the top level.
module lfu_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [63:0]      m_axis_tdata,
  input logic [1:0]       m_axis_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // One item at a time: the input closes right after a beat is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // Only a missed put can evict; checked here as: no eviction with a hit.
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("eviction reported on a hit");

  // Without an eviction the evicted key reads zero.
  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd0)
    else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (.*);
